### sv/lcdgs_pkg.sv
package lcdgs_pkg;

   // Panel geometry and glyph limits
   localparam int SCREEN_WIDTH    = 240;
   localparam int SCREEN_HEIGHT   = 320;
   localparam int MAX_GLYPH_WIDTH = 32;

   localparam logic [10:0] SCREEN_W_LIM = 11'(SCREEN_WIDTH);
   localparam logic [10:0] SCREEN_H_LIM = 11'(SCREEN_HEIGHT);
   localparam logic [7:0]  GLYPH_CAP    = (MAX_GLYPH_WIDTH > 32) ? 8'd32 : 8'(MAX_GLYPH_WIDTH);

   // Controller command bytes
   localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
   localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
   localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

   typedef enum logic [1:0] {
      FUNC_HEADER = 2'd0,
      FUNC_GLYPH  = 2'd1,
      FUNC_PIXEL  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HDR,
      ST_PIX
   } state_type;

   // Byte positions of the window-setup sequence
   typedef enum logic [3:0] {
      HS_CASET,
      HS_XS_HI,
      HS_XS_LO,
      HS_XE_HI,
      HS_XE_LO,
      HS_RASET,
      HS_YS_HI,
      HS_YS_LO,
      HS_YE_HI,
      HS_YE_LO,
      HS_RAMWR
   } hdr_step_type;

endpackage

### sv/lcd_window_glyph_pixel_streamer.sv
// Channel  | Ports                                             | Direction
// ---------+---------------------------------------------------+----------
// request  | req_valid/req_ready, req_func .. req_pixel         | in
// response | rsp_valid/rsp_ready, rsp_out_byte .. last_of_run   | out
//
// One response word per cycle, while the response is not stalled, leaves through a single output register.
// Header: accept, window check, then 11 words if the window lies on the screen.
// Glyph row: accept, then 2 words per pixel, up to 64 words.
// Image pixel: accept, then 2 words. Request is ready only when idle.
// A stalled response holds the sequencer; reset (synchronous) closes the window.
module lcd_window_glyph_pixel_streamer
   import lcdgs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [9:0]  req_origin_x,
   input  logic [9:0]  req_origin_y,
   input  logic [7:0]  req_win_width,
   input  logic [8:0]  req_win_height,
   input  logic [15:0] req_fg_color,
   input  logic [15:0] req_back_color,
   input  logic [31:0] req_row_bits,
   input  logic [15:0] req_pixel,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_data,
   output logic        rsp_ends_transfer,
   output logic        rsp_last_of_run
);

   // Sequencer and window state
   state_type    state_ff, state_in;
   hdr_step_type step_ff, step_in;
   logic         region_open_ff, region_open_in;
   logic [7:0]   region_width_ff, region_width_in;
   logic [15:0]  fore_ff, fore_in;
   logic [15:0]  back_ff, back_in;
   logic [16:0]  pixels_left_ff, pixels_left_in;

   // Header staging
   logic [9:0]   hdr_x_ff, hdr_x_in;
   logic [9:0]   hdr_y_ff, hdr_y_in;
   logic [7:0]   hdr_w_ff, hdr_w_in;
   logic [8:0]   hdr_h_ff, hdr_h_in;
   logic [10:0]  x2_ff, x2_in;
   logic [10:0]  y2_ff, y2_in;

   // Pixel run
   logic [31:0]  bits_ff, bits_in;
   logic         image_ff, image_in;
   logic [15:0]  pixel_ff, pixel_in;
   logic [5:0]   run_ff, run_in;
   logic         lo_ff, lo_in;

   // Output register
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_byte_ff, out_byte_in;
   logic         out_data_ff, out_data_in;
   logic         out_ends_ff, out_ends_in;
   logic         out_last_ff, out_last_in;

   // Working signals
   logic         req_fire;
   logic         can_load;
   logic         emit;
   logic [7:0]   emit_byte;
   logic         emit_data;
   logic         emit_ends;
   logic         emit_last;
   logic [10:0]  x2_calc;
   logic [10:0]  y2_calc;
   logic         win_bad;
   logic [7:0]   glyph_cap;
   logic [5:0]   glyph_count;
   logic [15:0]  pix_color;

   assign req_ready         = (state_ff == ST_IDLE);
   assign req_fire          = req_valid && req_ready;
   assign can_load          = !out_valid_ff || rsp_ready;

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_is_data       = out_data_ff;
   assign rsp_ends_transfer = out_ends_ff;
   assign rsp_last_of_run   = out_last_ff;

   // Window end points and bounds check
   assign x2_calc = 11'({1'b0, hdr_x_ff} + {3'b0, hdr_w_ff} - 11'd1);
   assign y2_calc = 11'({1'b0, hdr_y_ff} + {2'b0, hdr_h_ff} - 11'd1);
   assign win_bad = (hdr_w_ff == 8'd0) || (hdr_h_ff == 9'd0)
                 || ({1'b0, hdr_x_ff} >= SCREEN_W_LIM) || (x2_calc >= SCREEN_W_LIM)
                 || ({1'b0, hdr_y_ff} >= SCREEN_H_LIM) || (y2_calc >= SCREEN_H_LIM);

   // Pixels a glyph row may emit: window width, glyph cap, and pixels left
   assign glyph_cap   = (region_width_ff > GLYPH_CAP) ? GLYPH_CAP : region_width_ff;
   assign glyph_count = ({9'b0, glyph_cap} > pixels_left_ff) ? pixels_left_ff[5:0]
                                                             : glyph_cap[5:0];

   assign pix_color = image_ff ? pixel_ff : (bits_ff[31] ? fore_ff : back_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         step_ff         <= HS_CASET;
         region_open_ff  <= 1'b0;
         region_width_ff <= 8'd0;
         fore_ff         <= 16'd0;
         back_ff         <= 16'd0;
         pixels_left_ff  <= 17'd0;
         run_ff          <= 6'd0;
         lo_ff           <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         step_ff         <= step_in;
         region_open_ff  <= region_open_in;
         region_width_ff <= region_width_in;
         fore_ff         <= fore_in;
         back_ff         <= back_in;
         pixels_left_ff  <= pixels_left_in;
         run_ff          <= run_in;
         lo_ff           <= lo_in;
         out_valid_ff    <= out_valid_in;
      end
      hdr_x_ff    <= hdr_x_in;
      hdr_y_ff    <= hdr_y_in;
      hdr_w_ff    <= hdr_w_in;
      hdr_h_ff    <= hdr_h_in;
      x2_ff       <= x2_in;
      y2_ff       <= y2_in;
      bits_ff     <= bits_in;
      image_ff    <= image_in;
      pixel_ff    <= pixel_in;
      out_byte_ff <= out_byte_in;
      out_data_ff <= out_data_in;
      out_ends_ff <= out_ends_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      step_in         = step_ff;
      region_open_in  = region_open_ff;
      region_width_in = region_width_ff;
      fore_in         = fore_ff;
      back_in         = back_ff;
      pixels_left_in  = pixels_left_ff;
      hdr_x_in        = hdr_x_ff;
      hdr_y_in        = hdr_y_ff;
      hdr_w_in        = hdr_w_ff;
      hdr_h_in        = hdr_h_ff;
      x2_in           = x2_ff;
      y2_in           = y2_ff;
      bits_in         = bits_ff;
      image_in        = image_ff;
      pixel_in        = pixel_ff;
      run_in          = run_ff;
      lo_in           = lo_ff;
      emit            = 1'b0;
      emit_byte       = 8'd0;
      emit_data       = 1'b0;
      emit_ends       = 1'b0;
      emit_last       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_HEADER: begin
                     // Any header closes the current window at once.
                     hdr_x_in        = req_origin_x;
                     hdr_y_in        = req_origin_y;
                     hdr_w_in        = req_win_width;
                     hdr_h_in        = req_win_height;
                     region_width_in = req_win_width;
                     fore_in         = req_fg_color;
                     back_in         = req_back_color;
                     region_open_in  = 1'b0;
                     pixels_left_in  = 17'd0;
                     state_in        = ST_CHECK;
                  end
                  FUNC_GLYPH: begin
                     if (region_open_ff) begin
                        bits_in  = req_row_bits;
                        image_in = 1'b0;
                        run_in   = glyph_count;
                        lo_in    = 1'b0;
                        state_in = ST_PIX;
                     end
                  end
                  FUNC_PIXEL: begin
                     if (region_open_ff && (pixels_left_ff != 17'd0)) begin
                        pixel_in = req_pixel;
                        image_in = 1'b1;
                        run_in   = 6'd1;
                        lo_in    = 1'b0;
                        state_in = ST_PIX;
                     end
                  end
                  default: begin
                     // Unused selector: drop the word.
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (win_bad) begin
               state_in = ST_IDLE;
            end else begin
               x2_in          = x2_calc;
               y2_in          = y2_calc;
               pixels_left_in = {9'b0, hdr_w_ff} * {8'b0, hdr_h_ff};
               region_open_in = 1'b1;
               step_in        = HS_CASET;
               state_in       = ST_HDR;
            end
         end

         ST_HDR: begin
            emit      = can_load;
            emit_data = 1'b1;
            unique case (step_ff)
               HS_CASET: begin
                  emit_byte = CMD_COLUMN_SET;
                  emit_data = 1'b0;
               end
               HS_XS_HI: emit_byte = {6'b0, hdr_x_ff[9:8]};
               HS_XS_LO: emit_byte = hdr_x_ff[7:0];
               HS_XE_HI: emit_byte = {5'b0, x2_ff[10:8]};
               HS_XE_LO: begin
                  emit_byte = x2_ff[7:0];
                  emit_ends = 1'b1;
               end
               HS_RASET: begin
                  emit_byte = CMD_ROW_SET;
                  emit_data = 1'b0;
               end
               HS_YS_HI: emit_byte = {6'b0, hdr_y_ff[9:8]};
               HS_YS_LO: emit_byte = hdr_y_ff[7:0];
               HS_YE_HI: emit_byte = {5'b0, y2_ff[10:8]};
               HS_YE_LO: begin
                  emit_byte = y2_ff[7:0];
                  emit_ends = 1'b1;
               end
               HS_RAMWR: begin
                  emit_byte = CMD_MEMORY_WRITE;
                  emit_data = 1'b0;
                  emit_ends = 1'b1;
                  emit_last = 1'b1;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            if (emit) begin
               if (step_ff == HS_RAMWR) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = hdr_step_type'(4'(step_ff + 4'd1));
               end
            end
         end

         ST_PIX: begin
            emit      = can_load;
            emit_data = 1'b1;
            emit_byte = lo_ff ? pix_color[7:0] : pix_color[15:8];
            emit_ends = lo_ff && (pixels_left_ff == 17'd1);
            emit_last = lo_ff && (run_ff == 6'd1);
            if (emit) begin
               if (!lo_ff) begin
                  lo_in = 1'b1;
               end else begin
                  // Pixel done: advance the bitmap and count it against the window.
                  lo_in          = 1'b0;
                  bits_in        = {bits_ff[30:0], 1'b0};
                  run_in         = run_ff - 6'd1;
                  pixels_left_in = pixels_left_ff - 17'd1;
                  if (pixels_left_ff == 17'd1) begin
                     region_open_in = 1'b0;
                  end
                  if (run_ff == 6'd1) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load a new word, or drop the one just taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_data_in  = out_data_ff;
      out_ends_in  = out_ends_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_data_in  = emit_data;
         out_ends_in  = emit_ends;
         out_last_in  = emit_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // An open window always has pixels still to come.
   assert property (@(posedge clock) disable iff (reset)
      region_open_ff |-> (pixels_left_ff != 17'd0))
      else $error("open window with no pixels left");

   // A pixel run never outlasts the window.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |-> ((run_ff != 6'd0) && ({11'b0, run_ff} <= pixels_left_ff)))
      else $error("pixel run exceeds window");

   // The final pixel word of a window closes it.
   assert property (@(posedge clock) disable iff (reset)
      (emit && (state_ff == ST_PIX) && emit_ends) |=> !region_open_ff)
      else $error("window still open after final pixel");

   // Setup bytes are only sent for a window that lies on the screen.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HDR) |-> ((x2_ff < SCREEN_W_LIM) && (y2_ff < SCREEN_H_LIM)))
      else $error("window setup for off-screen window");

endmodule
